// File: sv/tii_pkg.sv
package tii_pkg;
  localparam int TABLE_DEPTH = 512;
  localparam int VALUE_WIDTH = 48;
  localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);
  localparam int COUNT_WIDTH = 10;
  localparam int PROD_WIDTH = 2 * VALUE_WIDTH;
  localparam int HALF_WIDTH = VALUE_WIDTH / 2;
  localparam int STEP_WIDTH = $clog2(PROD_WIDTH + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(500);
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    DP_IDLE  = 4'b0001,
    DP_WRITE = 4'b0010,
    DP_READ  = 4'b0100,
    DP_PROBE = 4'b1000
  } dp_op_t;

  typedef struct packed {
    logic       init;
    logic       load_write;
    logic       rd_mid;
    logic       take_mid;
    logic       rd_ends;
    logic       cap_lo;
    logic       cap_hi;
    logic       cap_first;
    logic       cap_last;
    logic       mul_step;
    logic       div_start;
    logic       div_step;
    logic       finish;
  } tii_cmd_t;

  typedef struct packed {
    logic search_done;
    logic mul_done;
    logic div_done;
  } tii_sts_t;
endpackage

// File: sv/tii_ram.sv
module tii_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/tii_datapath.sv
module tii_datapath
  import tii_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  tii_cmd_t               cmd,
  output tii_sts_t               sts,
  input  logic [COUNT_WIDTH-1:0] cfg_entry_count_i,
  input  logic [ADDR_WIDTH-1:0]  in_entry_index,
  input  logic [VALUE_WIDTH-1:0] in_abscissa_value,
  input  logic [VALUE_WIDTH-1:0] in_ordinate_value,
  output logic [VALUE_WIDTH-1:0] out_interpolated_value,
  output logic                   out_saturated,
  output logic                   out_extrapolated
);
  localparam logic [VALUE_WIDTH-1:0] VMAX = '1;

  logic [ADDR_WIDTH:0]    lo_r, lo_nxt, hi_r, hi_nxt, n;
  logic [ADDR_WIDTH:0]    mid;
  logic [ADDR_WIDTH-1:0]  raddr_x, raddr_y;
  logic [VALUE_WIDTH-1:0] v_r, xd, yd;
  logic [VALUE_WIDTH-1:0] xi_r, xj_r, yi_r, yj_r, first_r, last_r;
  logic [VALUE_WIDTH-1:0] dy, dv, dw;
  logic                   ndy, ndv, ndw;
  logic [PROD_WIDTH-1:0]  prod_r, rem_r, rem_nxt;
  logic [PROD_WIDTH-1:0]  quo_r;
  logic [PROD_WIDTH:0]    rsh;
  logic [1:0]             mstep_r;
  logic [STEP_WIDTH-1:0]  dstep_r;
  logic [HALF_WIDTH-1:0]  mb;
  logic [VALUE_WIDTH+HALF_WIDTH-1:0] pp;
  logic                   q_ovf;
  logic [VALUE_WIDTH-1:0] q;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] res_r;
  logic                   sat_r, ext_r;

  always_comb begin
    n = cfg_entry_count_i < COUNT_WIDTH'(2) ? (ADDR_WIDTH+1)'(2) :
        (cfg_entry_count_i > COUNT_WIDTH'(TABLE_DEPTH) ? (ADDR_WIDTH+1)'(TABLE_DEPTH) :
        (ADDR_WIDTH+1)'(cfg_entry_count_i));
    mid = (lo_r + hi_r) >> 1;
  end

  // port-a-like address steering: mid, ends, or first/last
  always_comb begin
    raddr_x = mid[ADDR_WIDTH-1:0];
    raddr_y = mid[ADDR_WIDTH-1:0];
    if (cmd.init) begin
      raddr_x = '0;
    end else if (cmd.rd_ends) begin
      raddr_x = lo_r[ADDR_WIDTH-1:0];
      raddr_y = lo_r[ADDR_WIDTH-1:0];
    end else if (cmd.cap_lo) begin
      raddr_x = hi_r[ADDR_WIDTH-1:0];
      raddr_y = hi_r[ADDR_WIDTH-1:0];
    end else if (cmd.cap_hi || cmd.mul_step) begin
      raddr_x = ADDR_WIDTH'(n - 1'b1);
    end
  end

  tii_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk, .we(cmd.load_write), .waddr(in_entry_index), .wdata(in_abscissa_value),
    .raddr(raddr_x), .rdata(xd));
  tii_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk, .we(cmd.load_write), .waddr(in_entry_index), .wdata(in_ordinate_value),
    .raddr(raddr_y), .rdata(yd));

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.init) begin
      lo_nxt = '0;
      hi_nxt = n - 1'b1;
    end else if (cmd.take_mid) begin
      if (v_r < xd) hi_nxt = mid;
      else lo_nxt = mid;
    end
  end

  assign sts.search_done = (lo_r + 1'b1) >= hi_r;
  assign sts.mul_done = mstep_r == 2'd2;
  assign sts.div_done = dstep_r == STEP_WIDTH'(PROD_WIDTH);

  always_comb begin
    ndy = yj_r < yi_r;
    dy = ndy ? yi_r - yj_r : yj_r - yi_r;
    ndv = v_r < xi_r;
    dv = ndv ? xi_r - v_r : v_r - xi_r;
    ndw = xj_r < xi_r;
    dw = ndw ? xi_r - xj_r : xj_r - xi_r;
    mb = mstep_r[0] ? dv[VALUE_WIDTH-1:HALF_WIDTH] : dv[HALF_WIDTH-1:0];
    pp = dy * mb;
    rsh = {rem_r, prod_r[PROD_WIDTH-1]};
    rem_nxt = rsh[PROD_WIDTH-1:0];
    if (rsh >= {{(VALUE_WIDTH+1){1'b0}}, dw}) begin
      rem_nxt = PROD_WIDTH'(rsh - {{(VALUE_WIDTH+1){1'b0}}, dw});
    end
    q_ovf = |quo_r[PROD_WIDTH-1:VALUE_WIDTH];
    q = q_ovf ? VMAX : quo_r[VALUE_WIDTH-1:0];
    sum = {1'b0, yi_r} + {1'b0, q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
      mstep_r <= '0;
      dstep_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      if (cmd.init) mstep_r <= '0;
      else if (cmd.mul_step) mstep_r <= mstep_r + 2'd1;
      if (cmd.div_start) dstep_r <= '0;
      else if (cmd.div_step) dstep_r <= dstep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) v_r <= in_abscissa_value;
    if (cmd.cap_lo) begin
      xi_r <= xd;
      yi_r <= yd;
    end
    if (cmd.cap_hi) begin
      xj_r <= xd;
      yj_r <= yd;
    end
    if (cmd.cap_first) first_r <= xd;
    if (cmd.cap_last) last_r <= xd;
    if (cmd.init) prod_r <= '0;
    else if (cmd.mul_step) begin
      if (mstep_r[0]) prod_r <= prod_r + (PROD_WIDTH'(pp) << HALF_WIDTH);
      else prod_r <= prod_r + PROD_WIDTH'(pp);
    end else if (cmd.div_step) prod_r <= {prod_r[PROD_WIDTH-2:0], 1'b0};
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[PROD_WIDTH-2:0], rsh >= {{(VALUE_WIDTH+1){1'b0}}, dw}};
    end
    if (cmd.finish) begin
      ext_r <= (v_r < first_r) || (v_r > last_r);
      sat_r <= 1'b0;
      if (v_r == xj_r) res_r <= yj_r;
      else if (v_r == xi_r || xi_r == xj_r) res_r <= yi_r;
      else if ((ndy ^ ndv) ^ ndw) begin
        if (q_ovf || q > yi_r) begin
          res_r <= '0;
          sat_r <= 1'b1;
        end else res_r <= yi_r - q;
      end else if (q_ovf || sum[VALUE_WIDTH]) begin
        res_r <= VMAX;
        sat_r <= 1'b1;
      end else res_r <= sum[VALUE_WIDTH-1:0];
    end
  end

  assign out_interpolated_value = res_r;
  assign out_saturated = sat_r;
  assign out_extrapolated = ext_r;
endmodule

// File: sv/tii_ctrl.sv
module tii_ctrl
  import tii_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_cmd,
  input  tii_sts_t sts,
  output tii_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MID   = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_ENDS  = 9'b000001000,
    S_CLO   = 9'b000010000,
    S_CHI   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_LOAD) cmd.load_write = 1'b1;
          else begin
            cmd.init = 1'b1;
            state_nxt = S_MID;
          end
        end
      end
      // first cycle also holds x[0] from init read
      S_MID: begin
        cmd.cap_first = 1'b1;
        if (sts.search_done) begin
          cmd.rd_ends = 1'b1;
          state_nxt = S_CLO;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.take_mid = 1'b1;
        state_nxt = S_ENDS;
      end
      S_ENDS: begin
        if (sts.search_done) begin
          cmd.rd_ends = 1'b1;
          state_nxt = S_CLO;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CLO: begin
        cmd.cap_lo = 1'b1;
        state_nxt = S_CHI;
      end
      S_CHI: begin
        cmd.cap_hi = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (sts.mul_done) begin
          cmd.cap_last = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else cmd.mul_step = 1'b1;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_nxt = S_DONE;
        end else cmd.div_step = 1'b1;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.finish;
    end
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = valid_r;
endmodule

// File: sv/table_inverse_interpolator.sv
// channel  | handshake        | payload
// in       | start / busy     | in_cmd, in_entry_index, in_abscissa_value, in_ordinate_value
// out      | out_valid strobe | out_interpolated_value, out_saturated, out_extrapolated
// cfg      | cfg_we           | cfg_entry_count
// a load is written while idle and leaves the block idle; a query keeps busy high until its
// result is strobed, through the bisection steps (S_CMP then S_ENDS) over the table ram read
// port and the bit-serial 96-bit divider (one quotient bit a cycle).
// synchronous active-low reset; table contents are not cleared.
// results are strobed for one cycle; the receiver cannot stall.
module table_inverse_interpolator
  import tii_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_cmd,
  input  logic [ADDR_WIDTH-1:0]  in_entry_index,
  input  logic [VALUE_WIDTH-1:0] in_abscissa_value,
  input  logic [VALUE_WIDTH-1:0] in_ordinate_value,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_interpolated_value,
  output logic                   out_saturated,
  output logic                   out_extrapolated,
  input  logic                   cfg_we,
  input  logic [COUNT_WIDTH-1:0] cfg_entry_count
);
  tii_cmd_t               cmd;
  tii_sts_t               sts;
  logic [COUNT_WIDTH-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= COUNT_RESET;
    else if (cfg_we) count_r <= cfg_entry_count;
  end

  tii_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_cmd, .sts, .cmd, .busy, .out_valid);

  tii_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_entry_count_i(count_r), .in_entry_index,
    .in_abscissa_value, .in_ordinate_value, .out_interpolated_value,
    .out_saturated, .out_extrapolated);
endmodule

// File: verif/tb_table_inverse_interpolator.sv
module tb_table_inverse_interpolator;
  import tii_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] VMAX = {VALUE_WIDTH{1'b1}};
  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef enum int {SHAPE_RISING, SHAPE_FLAT_RUNS, SHAPE_FALLING, SHAPE_SCRAMBLED} shape_t;

  typedef struct {
    logic                   cmd;
    logic [ADDR_WIDTH-1:0]  slot;
    logic [VALUE_WIDTH-1:0] xval;
    logic [VALUE_WIDTH-1:0] yval;
  } request_t;

  typedef struct {
    logic [VALUE_WIDTH-1:0] kappa;
    logic                   sat;
    logic                   ext;
  } answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_cmd = CMD_LOAD;
  logic [ADDR_WIDTH-1:0]  in_entry_index = '0;
  logic [VALUE_WIDTH-1:0] in_abscissa_value = '0;
  logic [VALUE_WIDTH-1:0] in_ordinate_value = '0;
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_interpolated_value;
  logic                   out_saturated;
  logic                   out_extrapolated;
  logic                   cfg_we = 1'b0;
  logic [COUNT_WIDTH-1:0] cfg_entry_count = '0;

  table_inverse_interpolator DUT (.*);

  always #6 clk = ~clk;

  // predictor state, updated as requests are accepted
  logic [VALUE_WIDTH-1:0] j_tab [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] kappa_tab [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] entries_used = COUNT_RESET;
  // abscissas as planned by the stimulus, ahead of acceptance
  logic [VALUE_WIDTH-1:0] planned_j [TABLE_DEPTH];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  request_t cur_req;
  bit       no_idle = 0;
  int       errors = 0;
  int       answers_seen = 0, n_sat = 0, n_ext = 0, n_loads = 0;
  longint   cycles = 0;

  function automatic answer_t interpolate(input logic [VALUE_WIDTH-1:0] v);
    answer_t a;
    int n, lo, hi, mid;
    logic [VALUE_WIDTH-1:0] xi, xj, yi, yj, dy, dv, dw;
    logic ndy, ndv, ndw;
    logic [PROD_WIDTH-1:0] q;
    n = int'(entries_used);
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    lo = 0;
    hi = n - 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) / 2;
      if (v < j_tab[mid]) hi = mid; else lo = mid;
    end
    xi = j_tab[lo];
    xj = j_tab[hi];
    yi = kappa_tab[lo];
    yj = kappa_tab[hi];
    a.sat = 1'b0;
    a.ext = (v < j_tab[0]) || (v > j_tab[n-1]);
    if (v == xj) begin
      a.kappa = yj;
    end else if (v == xi || xi == xj) begin
      a.kappa = yi;
    end else begin
      ndy = yj < yi;
      dy = ndy ? yi - yj : yj - yi;
      ndv = v < xi;
      dv = ndv ? xi - v : v - xi;
      ndw = xj < xi;
      dw = ndw ? xi - xj : xj - xi;
      q = (PROD_WIDTH'(dy) * PROD_WIDTH'(dv)) / PROD_WIDTH'(dw);
      if ((ndy != ndv) != ndw) begin
        if (q > PROD_WIDTH'(yi)) begin
          a.kappa = '0;
          a.sat = 1'b1;
        end else a.kappa = yi - q[VALUE_WIDTH-1:0];
      end else begin
        if (q > PROD_WIDTH'(VMAX - yi)) begin
          a.kappa = VMAX;
          a.sat = 1'b1;
        end else a.kappa = yi + q[VALUE_WIDTH-1:0];
      end
    end
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_req.cmd == CMD_LOAD) begin
          j_tab[cur_req.slot] = cur_req.xval;
          kappa_tab[cur_req.slot] = cur_req.yval;
          n_loads++;
        end else begin
          expected_answers.push_back(interpolate(cur_req.xval));
        end
      end
      if (!(start && busy)) begin
        if (pending_reqs.size() == 0 ||
            (!no_idle && $urandom_range(0, 99) < 7)) begin
          start <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          start <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_entry_index <= cur_req.slot;
          in_abscissa_value <= cur_req.xval;
          in_ordinate_value <= cur_req.yval;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    cycles++;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result, kappa %h", out_interpolated_value);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        answers_seen++;
        if (e.sat) n_sat++;
        if (e.ext) n_ext++;
        if (out_interpolated_value !== e.kappa) begin
          $error("interpolated_value: expected %h, got %h", e.kappa, out_interpolated_value);
          errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %b, got %b", e.sat, out_saturated);
          errors++;
        end
        if (out_extrapolated !== e.ext) begin
          $error("extrapolated: expected %b, got %b", e.ext, out_extrapolated);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[table_inverse_interpolator] ERROR");
      $finish;
    end
  end

  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    return VALUE_WIDTH'({$urandom, $urandom});
  endfunction

  task automatic push_load(input int slot, input logic [VALUE_WIDTH-1:0] x,
                           input logic [VALUE_WIDTH-1:0] y);
    request_t r;
    r.cmd = CMD_LOAD;
    r.slot = ADDR_WIDTH'(slot);
    r.xval = x;
    r.yval = y;
    planned_j[slot] = x;
    pending_reqs.push_back(r);
  endtask

  task automatic push_query(input logic [VALUE_WIDTH-1:0] v);
    request_t r;
    r.cmd = CMD_QUERY;
    r.slot = ADDR_WIDTH'($urandom);
    r.xval = v;
    r.yval = rand_value();
    pending_reqs.push_back(r);
  endtask

  // sender holds off until the block has drained, then the extra latency
  task automatic drain();
    while (pending_reqs.size() != 0 || start || busy || expected_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(input int cnt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_entry_count <= COUNT_WIDTH'(cnt);
    entries_used = COUNT_WIDTH'(cnt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_table(input shape_t shape, input int upto);
    logic [VALUE_WIDTH-1:0] x;
    x = VALUE_WIDTH'($urandom_range(0, 1 << 20));
    for (int k = 0; k < upto; k++) begin
      case (shape)
        SHAPE_RISING: x = x + 1 + VALUE_WIDTH'({$urandom_range(0, 63), $urandom});
        SHAPE_FLAT_RUNS: if ($urandom_range(0, 2) != 0)
          x = x + 1 + VALUE_WIDTH'($urandom_range(0, 1 << 24));
        SHAPE_FALLING: x = x + 1 + VALUE_WIDTH'({$urandom_range(0, 63), $urandom});
        default: x = rand_value();
      endcase
      push_load(k, x, shape == SHAPE_FALLING ? VMAX - VALUE_WIDTH'(k) * 48'h10_0000_0000
                                             : rand_value());
    end
  endtask

  function automatic logic [VALUE_WIDTH-1:0] pick_query(input int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 9))
      0, 1: return rand_value();
      2, 3: return planned_j[k];
      8: return '0;
      9: return VMAX;
      default: return planned_j[k] + VALUE_WIDTH'($urandom) - VALUE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int cnt, input shape_t shape, input int nq,
                           input bit reloads, input bit quiet);
    int n;
    drain();
    set_entry_count(cnt);
    n = (cnt < 2) ? 2 : (cnt > TABLE_DEPTH ? TABLE_DEPTH : cnt);
    fill_table(shape, n);
    no_idle = quiet;
    for (int q = 0; q < nq; q++) begin
      if (reloads && $urandom_range(0, 4) == 0)
        push_load($urandom_range(0, n - 1), rand_value(), rand_value());
      push_query(pick_query(n));
    end
  endtask

  initial begin
    logic [VALUE_WIDTH-1:0] x;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // every slot gets written once so no query ever reads an unwritten entry
    x = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k == TABLE_DEPTH - 1) x = VMAX;
      else if (k > 0) x = x + 1 + VALUE_WIDTH'({$urandom_range(0, 63), $urandom});
      push_load(k, x, k == 0 ? '0 : (k == TABLE_DEPTH - 1 ? VMAX : rand_value()));
    end
    // directed queries with the reset entry count
    push_query('0);
    push_query(VMAX);
    push_query(planned_j[0]);
    push_query(planned_j[499]);
    push_query(planned_j[499] + 1);
    push_query(planned_j[250]);
    push_query(planned_j[250] + 1);
    push_query(planned_j[250] - 1);
    push_query(planned_j[1] - 1);
    push_query(planned_j[0] + 1);
    push_query(planned_j[498] + 1);
    push_query(48'hAAAA_AAAA_AAAA);
    push_query(48'h5555_5555_5555);
    for (int q = 0; q < 100; q++) push_query(pick_query(500));
    run_phase(2, SHAPE_RISING, 60, 1'b0, 1'b0);
    run_phase(64, SHAPE_RISING, 120, 1'b0, 1'b1);
    run_phase(1023, SHAPE_FLAT_RUNS, 100, 1'b0, 1'b0);
    run_phase(0, SHAPE_FALLING, 60, 1'b0, 1'b0);
    run_phase($urandom_range(2, 128), SHAPE_SCRAMBLED, 60, 1'b0, 1'b0);
    run_phase(37, SHAPE_RISING, 40, 1'b1, 1'b0);
    drain();
    $display("covered %0d queries and %0d table loads over seven entry counts", answers_seen,
             n_loads);
    $display("saturated answers %0d, extrapolated answers %0d", n_sat, n_ext);
    if (errors == 0) begin
      $display("[table_inverse_interpolator] OK");
    end else begin
      $display("[table_inverse_interpolator] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tii_pkg.sv
sv/tii_ram.sv
sv/tii_datapath.sv
sv/tii_ctrl.sv
sv/table_inverse_interpolator.sv
verif/tb_table_inverse_interpolator.sv
